// File: design/palette_bit_packer_assert.svh
// Assertion macros used by the palette bit packer top level (design/palette_bit_packer.sv).
`ifndef PALETTE_BIT_PACKER_ASSERT_SVH
`define PALETTE_BIT_PACKER_ASSERT_SVH

`ifndef SYNTHESIS

// Property that holds at every clock edge outside reset.
`define PBP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Property whose consequence holds in the cycle after the condition.
`define PBP_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`else

`define PBP_ASSERT(label, prop, msg)
`define PBP_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

// File: design/pbp_pkg.sv
// Package with constants, types and helper functions of the palette bit packer.
`timescale 1ns / 1ps

package pbp_pkg;

    localparam int SECTION_BLOCKS = 4096;
    localparam int PALETTE_MAX    = 256;
    localparam int ID_BITS        = 15;
    localparam int MIN_BITS       = 4;
    localparam int MAX_PAL_BITS   = 8;
    localparam int WORD_BITS      = 64;

    localparam int ENTRY_AW = $clog2(SECTION_BLOCKS);
    localparam int LOAD_W   = ENTRY_AW + 1;
    localparam int PAL_AW   = $clog2(PALETTE_MAX);
    localparam int SIZE_W   = PAL_AW + 1;
    localparam int BITS_W   = 4;
    localparam int WCNT_W   = 10;
    localparam int ENTRY_W  = ID_BITS + PAL_AW;
    localparam int ACC_W    = WORD_BITS + 16;
    localparam int ACNT_W   = 7;
    localparam int PROD_W   = ENTRY_AW + BITS_W + 1;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic [2:0] KIND_COUNT   = 3'd0;
    localparam logic [2:0] KIND_BITS    = 3'd1;
    localparam logic [2:0] KIND_PAL_LEN = 3'd2;
    localparam logic [2:0] KIND_PAL_ENT = 3'd3;
    localparam logic [2:0] KIND_WCOUNT  = 3'd4;
    localparam logic [2:0] KIND_WORD    = 3'd5;

    typedef struct packed {
        logic        func;
        logic [14:0] block_id;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] value;
        logic        last;
    } out_item_t;

    typedef enum logic [2:0] {
        PH_COUNT,
        PH_BITS,
        PH_PAL_LEN,
        PH_PAL_ENT,
        PH_WCOUNT,
        PH_WORD
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_WORD,
        ST_WORD_CAP,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic              clear;
        logic              fetch;
        logic              capture;
        logic              shift;
        logic              direct;
        logic [BITS_W-1:0] bits;
    } pack_ctrl_t;

    typedef struct packed {
        logic word_ready;
    } pack_stat_t;

    // Bits per entry: max(MIN_BITS, ceil(log2(size))), or the full id width.
    function automatic logic [BITS_W-1:0] entry_bits(input logic [SIZE_W-1:0] size,
                                                      input logic overflow);
        logic [SIZE_W-1:0] sm1;
        logic [BITS_W-1:0] k;
        sm1 = size - SIZE_W'(1);
        k   = '0;
        for (int j = 0; j < SIZE_W; j++) begin
            if (sm1[j]) begin
                k = BITS_W'(j + 1);
            end
        end
        if (k < BITS_W'(MIN_BITS)) begin
            k = BITS_W'(MIN_BITS);
        end
        if (overflow || (k > BITS_W'(MAX_PAL_BITS))) begin
            k = BITS_W'(ID_BITS);
        end
        return k;
    endfunction

    function automatic logic [WCNT_W-1:0] word_total(input logic [BITS_W-1:0] bits);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(bits) * PROD_W'(SECTION_BLOCKS) + PROD_W'(WORD_BITS - 1);
        return WCNT_W'(prod >> 6);
    endfunction

endpackage

// File: design/pbp_ram.sv
// Simple dual-port synchronous RAM with a registered read.
`timescale 1ns / 1ps

module pbp_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// File: design/pbp_packer.sv
// Bit accumulator that packs section entries LSB first into 64-bit words.
`timescale 1ns / 1ps

module pbp_packer import pbp_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  pack_ctrl_t          ctrl,
    input  logic [ENTRY_W-1:0]  rd_data,
    output logic [ENTRY_AW-1:0] rd_addr,
    output pack_stat_t          stat,
    output logic [63:0]         word
);

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACNT_W-1:0] cnt_reg, cnt_next;
    logic [LOAD_W-1:0] eptr_reg, eptr_next;
    logic [ID_BITS-1:0] entry_val;
    logic all_fetched;

    assign all_fetched = (eptr_reg == LOAD_W'(SECTION_BLOCKS));
    assign entry_val   = ctrl.direct ? rd_data[ENTRY_W-1:PAL_AW]
                                     : ID_BITS'(rd_data[PAL_AW-1:0]);
    assign rd_addr     = eptr_reg[ENTRY_AW-1:0];
    assign word        = acc_reg[63:0];
    assign stat.word_ready = (cnt_reg >= ACNT_W'(WORD_BITS)) || all_fetched;

    always_comb begin
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        eptr_next = eptr_reg;
        if (ctrl.clear) begin
            acc_next  = '0;
            cnt_next  = '0;
            eptr_next = '0;
        end else begin
            if (ctrl.fetch) begin
                eptr_next = eptr_reg + LOAD_W'(1);
            end
            if (ctrl.capture) begin
                acc_next = acc_reg | (ACC_W'(entry_val) << cnt_reg);
                cnt_next = cnt_reg + ACNT_W'(ctrl.bits);
            end
            if (ctrl.shift) begin
                acc_next = acc_reg >> WORD_BITS;
                cnt_next = (cnt_reg >= ACNT_W'(WORD_BITS)) ?
                           cnt_reg - ACNT_W'(WORD_BITS) : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            cnt_reg  <= '0;
            eptr_reg <= '0;
        end else begin
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            eptr_reg <= eptr_next;
        end
    end

endmodule

// File: design/palette_bit_packer.sv
// Top level: palette building on load and tagged result sequencing on read.
// Load item: air needs no palette search; other ids are compared with the stored palette
// entries, the search walking the palette memory one entry per read.
// Result item: passes through the result register to the output register; a packed
// word first fetches entries from the entry memory (up to 16 entries per word).
// One item in work at a time; a finished result waits in the output register.
// Reset (aresetn low at a clock edge) clears control state; memories are not cleared.
`timescale 1ns / 1ps
`include "palette_bit_packer_assert.svh"

module palette_bit_packer import pbp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_payload
);

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic               ovf_reg, ovf_next;
    logic [LOAD_W-1:0]  nonair_reg, nonair_next;
    logic [LOAD_W-1:0]  load_reg, load_next;
    logic [WCNT_W-1:0]  ptr_reg, ptr_next;
    in_item_t           item_reg;
    out_item_t          res_reg, res_next;
    out_item_t          out_reg;
    logic               m_valid_reg;

    logic [BITS_W-1:0]  bits_c;
    logic [WCNT_W-1:0]  total_c;
    logic               direct_c;
    logic               full_c;
    logic [WCNT_W-1:0]  ptr_inc;
    logic               resolve, miss, hit;
    logic [PAL_AW-1:0]  found_c;
    logic               pal_we;
    logic [ID_BITS-1:0] pal_rdata;
    logic [ENTRY_W-1:0] ent_rdata;
    logic [ENTRY_AW-1:0] ent_raddr;
    logic               out_free;
    logic               last_c;
    pack_ctrl_t         pctrl;
    pack_stat_t         pstat;
    logic [63:0]        pword;

    assign bits_c   = entry_bits(size_reg, ovf_reg);
    assign direct_c = (bits_c > BITS_W'(MAX_PAL_BITS));
    assign total_c  = word_total(bits_c);
    assign full_c   = (load_reg == LOAD_W'(SECTION_BLOCKS));
    assign ptr_inc  = ptr_reg + WCNT_W'(1);
    assign hit      = (pal_rdata == item_reg.block_id);
    assign out_free = !m_valid_reg || m_ready;
    assign last_c   = (ptr_inc == total_c);

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    pbp_ram #(.DEPTH(PALETTE_MAX), .WIDTH(ID_BITS)) u_pal_ram (
        .aclk    (aclk),
        .wr_en   (pal_we),
        .wr_addr (size_reg[PAL_AW-1:0]),
        .wr_data (item_reg.block_id),
        .rd_addr (ptr_reg[PAL_AW-1:0]),
        .rd_data (pal_rdata)
    );

    pbp_ram #(.DEPTH(SECTION_BLOCKS), .WIDTH(ENTRY_W)) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (resolve),
        .wr_addr (load_reg[ENTRY_AW-1:0]),
        .wr_data ({item_reg.block_id, found_c}),
        .rd_addr (ent_raddr),
        .rd_data (ent_rdata)
    );

    pbp_packer u_packer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (pctrl),
        .rd_data (ent_rdata),
        .rd_addr (ent_raddr),
        .stat    (pstat),
        .word    (pword)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (item_reg.func == FUNC_LOAD) begin
                    if (full_c || item_reg.block_id == '0 || size_reg == SIZE_W'(1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_SRCH_RD;
                    end
                end else if (!full_c) begin
                    state_next = ST_IDLE;
                end else if (phase_reg == PH_WORD) begin
                    state_next = ST_WORD;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_SRCH_RD: begin
                state_next = ST_SRCH_CMP;
            end
            ST_SRCH_CMP: begin
                if (hit || ptr_inc == WCNT_W'(size_reg)) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_SRCH_RD;
                end
            end
            ST_WORD: begin
                state_next = pstat.word_ready ? ST_RESULT : ST_WORD_CAP;
            end
            ST_WORD_CAP: begin
                state_next = ST_WORD;
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath updates and outputs.
    always_comb begin
        phase_next  = phase_reg;
        size_next   = size_reg;
        ovf_next    = ovf_reg;
        nonair_next = nonair_reg;
        load_next   = load_reg;
        ptr_next    = ptr_reg;
        res_next    = res_reg;
        resolve     = 1'b0;
        miss        = 1'b0;
        found_c     = '0;
        pctrl       = '{clear: 1'b0, fetch: 1'b0, capture: 1'b0, shift: 1'b0,
                        direct: direct_c, bits: bits_c};
        case (state_reg)
            ST_EXEC: begin
                if (item_reg.func == FUNC_LOAD) begin
                    if (!full_c) begin
                        if (item_reg.block_id == '0) begin
                            resolve = 1'b1;
                        end else if (size_reg == SIZE_W'(1)) begin
                            resolve = 1'b1;
                            miss    = 1'b1;
                        end else begin
                            ptr_next = WCNT_W'(1);
                        end
                    end
                end else if (full_c) begin
                    res_next.last = 1'b0;
                    case (phase_reg)
                        PH_COUNT: begin
                            res_next.kind  = KIND_COUNT;
                            res_next.value = 64'(nonair_reg);
                            phase_next     = PH_BITS;
                        end
                        PH_BITS: begin
                            res_next.kind  = KIND_BITS;
                            res_next.value = 64'(bits_c);
                            phase_next     = direct_c ? PH_WCOUNT : PH_PAL_LEN;
                        end
                        PH_PAL_LEN: begin
                            res_next.kind  = KIND_PAL_LEN;
                            res_next.value = 64'(size_reg);
                            phase_next     = PH_PAL_ENT;
                            ptr_next       = '0;
                        end
                        PH_PAL_ENT: begin
                            // Entry 0 is always air and is never stored.
                            res_next.kind  = KIND_PAL_ENT;
                            res_next.value = (ptr_reg == '0) ? 64'd0 : 64'(pal_rdata);
                            ptr_next       = ptr_inc;
                            if (ptr_inc >= WCNT_W'(size_reg)) begin
                                phase_next = PH_WCOUNT;
                                ptr_next   = '0;
                            end
                        end
                        PH_WCOUNT: begin
                            res_next.kind  = KIND_WCOUNT;
                            res_next.value = 64'(total_c);
                            phase_next     = PH_WORD;
                            ptr_next       = '0;
                            pctrl.clear    = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SRCH_CMP: begin
                if (hit) begin
                    resolve = 1'b1;
                    found_c = ptr_reg[PAL_AW-1:0];
                end else if (ptr_inc == WCNT_W'(size_reg)) begin
                    resolve = 1'b1;
                    miss    = 1'b1;
                end else begin
                    ptr_next = ptr_inc;
                end
            end
            ST_WORD: begin
                if (pstat.word_ready) begin
                    res_next.kind  = KIND_WORD;
                    res_next.value = pword;
                    res_next.last  = last_c;
                    pctrl.shift    = 1'b1;
                    ptr_next       = ptr_inc;
                    if (last_c) begin
                        size_next   = SIZE_W'(1);
                        ovf_next    = 1'b0;
                        nonair_next = '0;
                        load_next   = '0;
                        phase_next  = PH_COUNT;
                        ptr_next    = '0;
                    end
                end else begin
                    pctrl.fetch = 1'b1;
                end
            end
            ST_WORD_CAP: begin
                pctrl.capture = 1'b1;
            end
            default: begin
            end
        endcase

        pal_we = 1'b0;
        if (resolve) begin
            if (miss) begin
                if (size_reg < SIZE_W'(PALETTE_MAX)) begin
                    found_c   = size_reg[PAL_AW-1:0];
                    pal_we    = 1'b1;
                    size_next = size_reg + SIZE_W'(1);
                end else begin
                    ovf_next = 1'b1;
                end
            end
            load_next = load_reg + LOAD_W'(1);
            if (item_reg.block_id != '0) begin
                nonair_next = nonair_reg + LOAD_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_COUNT;
            size_reg    <= SIZE_W'(1);
            ovf_reg     <= 1'b0;
            nonair_reg  <= '0;
            load_reg    <= '0;
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            size_reg   <= size_next;
            ovf_reg    <= ovf_next;
            nonair_reg <= nonair_next;
            load_reg   <= load_next;
            ptr_reg    <= ptr_next;
            if (state_reg == ST_RESULT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_payload;
        end
        res_reg <= res_next;
        if (state_reg == ST_RESULT && out_free) begin
            out_reg <= res_reg;
        end
    end

    `PBP_ASSERT(a_size_range, (size_reg != '0) && (size_reg <= SIZE_W'(PALETTE_MAX)), "palette size out of range")
    `PBP_ASSERT(a_ovf_full, !ovf_reg || (size_reg == SIZE_W'(PALETTE_MAX)), "overflow with free palette entries")
    `PBP_ASSERT(a_last_word, !(m_valid_reg && out_reg.last) || (out_reg.kind == KIND_WORD), "last flag on a non-word result")
    `PBP_ASSERT_NEXT(a_section_clear, (state_reg == ST_WORD) && pstat.word_ready && last_c, (load_reg == '0) && (phase_reg == PH_COUNT), "section state not cleared after final word")
    `PBP_ASSERT(a_load_bound, load_reg <= LOAD_W'(SECTION_BLOCKS), "load count beyond section size")

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the palette bit packer: section loads, tagged reads, packed words.
`timescale 1ns / 1ps

module tb_top;
    import pbp_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        logic        func;
        logic [14:0] id;
        int          reps;
        bit          typed;
        logic [2:0]  kind;
        logic [63:0] value;
        logic        last;
    } step_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_payload;

    // Shadow copy of the section state.
    logic [14:0] sec_ids[SECTION_BLOCKS];
    logic [7:0]  sec_index[SECTION_BLOCKS];
    logic [14:0] pal_ids[PALETTE_MAX];
    int          pal_size;
    bit          pal_overflow;
    int          nonair;
    int          loaded;
    int          phase;
    int          pointer;
    bit          section_closed;

    out_item_t   pending_results[$];
    int          error_count = 0;
    int          idle_cycles = 0;
    bit          rx_calm = 1'b0;
    int          rx_hold = 0;
    step_t       plan[16];

    palette_bit_packer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #4 aclk = ~aclk;

    function automatic void clear_section();
        pal_ids[0] = '0;
        pal_size = 1;
        pal_overflow = 1'b0;
        nonair = 0;
        loaded = 0;
        phase = 0;
        pointer = 0;
    endfunction

    function automatic int bits_per_entry();
        int k;
        k = 0;
        if (pal_overflow) begin
            return ID_BITS;
        end
        while ((1 << k) < pal_size) k++;
        if (k < MIN_BITS) k = MIN_BITS;
        if (k > MAX_PAL_BITS) k = ID_BITS;
        return k;
    endfunction

    function automatic int words_in_section();
        return (SECTION_BLOCKS * bits_per_entry() + 63) / 64;
    endfunction

    function automatic logic [63:0] pack_word(int w);
        int b;
        int lo;
        int first;
        int fin;
        int s;
        logic [63:0] acc;
        logic [63:0] v;
        b = bits_per_entry();
        lo = w * 64;
        first = lo / b;
        fin = (lo + 63) / b;
        acc = '0;
        if (fin > SECTION_BLOCKS - 1) fin = SECTION_BLOCKS - 1;
        for (int e = first; e <= fin; e++) begin
            v = (b > MAX_PAL_BITS) ? 64'(sec_ids[e]) : 64'(sec_index[e]);
            s = e * b;
            if (s >= lo) acc |= v << (s - lo);
            else acc |= v >> (lo - s);
        end
        return acc;
    endfunction

    // Advances the shadow state by one accepted transfer; returns 1 when a result is due.
    function automatic bit predict_result(input in_item_t it, output out_item_t r);
        int found;
        bit hit;
        r = '0;
        if (it.func == FUNC_LOAD) begin
            if (loaded < SECTION_BLOCKS) begin
                sec_ids[loaded] = it.block_id;
                if (it.block_id != 0) nonair++;
                found = 0;
                hit = 1'b0;
                for (int i = 0; i < pal_size && i < PALETTE_MAX; i++) begin
                    if (!hit && pal_ids[i] == it.block_id) begin
                        found = i;
                        hit = 1'b1;
                    end
                end
                if (!hit) begin
                    if (pal_size < PALETTE_MAX) begin
                        found = pal_size;
                        pal_ids[pal_size] = it.block_id;
                        pal_size++;
                    end else begin
                        pal_overflow = 1'b1;
                    end
                end
                sec_index[loaded] = 8'(found);
                loaded++;
            end
            return 1'b0;
        end
        if (loaded < SECTION_BLOCKS) return 1'b0;
        case (phase)
            0: begin
                r.kind = KIND_COUNT;
                r.value = 64'(nonair);
                phase = 1;
            end
            1: begin
                r.kind = KIND_BITS;
                r.value = 64'(bits_per_entry());
                phase = (bits_per_entry() > MAX_PAL_BITS) ? 4 : 2;
            end
            2: begin
                r.kind = KIND_PAL_LEN;
                r.value = 64'(pal_size);
                phase = 3;
                pointer = 0;
            end
            3: begin
                r.kind = KIND_PAL_ENT;
                r.value = 64'(pal_ids[pointer]);
                pointer++;
                if (pointer >= pal_size) begin
                    phase = 4;
                    pointer = 0;
                end
            end
            4: begin
                r.kind = KIND_WCOUNT;
                r.value = 64'(words_in_section());
                phase = 5;
                pointer = 0;
            end
            default: begin
                r.kind = KIND_WORD;
                r.value = pack_word(pointer);
                pointer++;
                if (pointer >= words_in_section()) begin
                    r.last = 1'b1;
                    section_closed = 1'b1;
                    clear_section();
                end
            end
        endcase
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Presents one transfer; valid stays high across back-to-back transfers.
    task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_res);
        int gap;
        int roll;
        out_item_t r;
        roll = $urandom_range(0, 99);
        gap = (roll < 70) ? 0 : (roll < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (predict_result(it, r) || typed) begin
            pending_results = {pending_results, (typed ? typed_res : r)};
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic random_section(input int distinct);
        logic [14:0] pool[$];
        bit          used[logic [14:0]];
        logic [14:0] id;
        int          k;
        in_item_t    it;
        pool.delete();
        used.delete();
        while (pool.size() < distinct) begin
            id = 15'($urandom_range(1, 32767));
            if (!used.exists(id)) begin
                used[id] = 1'b1;
                pool = {pool, id};
            end
        end
        for (int n = 0; n < 2; n++) begin
            it.func = FUNC_READ;
            it.block_id = 15'($urandom);
            send_item(it, 1'b0, '0);
        end
        k = 0;
        for (int i = 0; i < SECTION_BLOCKS; i++) begin
            it.func = FUNC_LOAD;
            if (k < distinct && ($urandom_range(0, 3) == 0 || SECTION_BLOCKS - i <= distinct - k))
            begin
                it.block_id = pool[k];
                k++;
            end else if (k > 0 && $urandom_range(0, (distinct <= 40) ? 3 : 19) == 0) begin
                it.block_id = pool[$urandom_range(0, k - 1)];
            end else begin
                it.block_id = '0;
            end
            send_item(it, 1'b0, '0);
        end
        it.func = FUNC_LOAD;
        it.block_id = 15'($urandom);
        send_item(it, 1'b0, '0);
        section_closed = 1'b0;
        while (!section_closed) begin
            it.func = FUNC_READ;
            it.block_id = 15'($urandom);
            send_item(it, 1'b0, '0);
        end
    endtask

    // Receiver stalls: mostly short, now and then long, none at all in calm sections.
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= 1'b0;
        end else if (rx_calm) begin
            m_ready <= 1'b1;
        end else begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3: begin
                    m_ready <= 1'b0;
                    rx_hold <= $urandom_range(0, 2);
                end
                4: begin
                    m_ready <= 1'b0;
                    rx_hold <= $urandom_range(20, 60);
                end
                default: m_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 64'(m_payload.kind), 64'hx);
            end else begin
                want = pending_results.pop_front();
                if (m_payload.kind !== want.kind)
                    report_mismatch("kind", 64'(m_payload.kind), 64'(want.kind));
                if (m_payload.value !== want.value)
                    report_mismatch("value", m_payload.value, want.value);
                if (m_payload.last !== want.last)
                    report_mismatch("last", 64'(m_payload.last), 64'(want.last));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int        sizes[2];
        in_item_t  it;
        out_item_t typed_res;
        sizes = '{16, 300};
        plan = '{
            '{FUNC_READ, 15'h1234, 1,    1'b0, KIND_COUNT,   64'd0, 1'b0},
            '{FUNC_LOAD, 15'h7fff, 1,    1'b0, KIND_COUNT,   64'd0, 1'b0},
            '{FUNC_LOAD, 15'h0000, 4094, 1'b0, KIND_COUNT,   64'd0, 1'b0},
            '{FUNC_LOAD, 15'h0001, 1,    1'b0, KIND_COUNT,   64'd0, 1'b0},
            '{FUNC_LOAD, 15'h2aaa, 1,    1'b0, KIND_COUNT,   64'd0, 1'b0},
            '{FUNC_READ, 15'h5555, 1,    1'b1, KIND_COUNT,   64'd2, 1'b0},
            '{FUNC_READ, 15'h0000, 1,    1'b1, KIND_BITS,    64'd4, 1'b0},
            '{FUNC_READ, 15'h0000, 1,    1'b1, KIND_PAL_LEN, 64'd3, 1'b0},
            '{FUNC_READ, 15'h0000, 1,    1'b1, KIND_PAL_ENT, 64'd0, 1'b0},
            '{FUNC_READ, 15'h0000, 1,    1'b1, KIND_PAL_ENT, 64'd32767, 1'b0},
            '{FUNC_READ, 15'h0000, 1,    1'b1, KIND_PAL_ENT, 64'd1, 1'b0},
            '{FUNC_READ, 15'h0000, 1,    1'b1, KIND_WCOUNT,  64'd256, 1'b0},
            '{FUNC_READ, 15'h7fff, 1,    1'b1, KIND_WORD,    64'd1, 1'b0},
            '{FUNC_READ, 15'h0000, 254,  1'b0, KIND_WORD,    64'd0, 1'b0},
            '{FUNC_READ, 15'h0000, 1,    1'b1, KIND_WORD,    64'h2000000000000000, 1'b1},
            '{FUNC_READ, 15'h0000, 1,    1'b0, KIND_COUNT,   64'd0, 1'b0}
        };
        clear_section();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[r]) begin
            for (int n = 0; n < plan[r].reps; n++) begin
                it.func = plan[r].func;
                it.block_id = plan[r].id;
                typed_res.kind = plan[r].kind;
                typed_res.value = plan[r].value;
                typed_res.last = plan[r].last;
                send_item(it, plan[r].typed, typed_res);
            end
        end

        for (int s = 0; s < 2; s++) begin
            drain_results();
            rx_calm = (s == 1);
            random_section(sizes[s]);
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/pbp_pkg.sv
design/pbp_ram.sv
design/pbp_packer.sv
design/palette_bit_packer.sv
verif/tb_top.sv
